@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that is also checked during reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/sbd_pkg.sv @@
// types, codes and table builders for the srgb 2x2 downsampler
// no dependencies
package sbd_pkg;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 13;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SOURCE_WIDTH  = 4'd0,
      CSR_SOURCE_HEIGHT = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       last_of_level;
   } rsp_payload_type;

   // integer power on wide vectors, elaboration only
   function automatic logic [255:0] big_pow(input logic [255:0] base, input int ex);
      logic [255:0] r;
      r = 256'd1;
      for (int k = 0; k < ex; k++) begin
         r = r * base;
      end
      return r;
   endfunction

   // round-half-up of m*(i/255)^2.2, decided exactly
   function automatic int lin_entry(input int i, input int lb);
      logic [255:0] m;
      logic [255:0] lhs;
      logic [255:0] rhs;
      int lo;
      int hi;
      int mid;
      m   = (256'd1 << lb) - 256'd1;
      rhs = 256'd32 * big_pow(m, 5) * big_pow(256'(i), 11);
      lo  = 0;
      hi  = (1 << lb) - 1;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 1) >> 1);
         lhs = big_pow(256'(2 * mid - 1), 5) * big_pow(256'd255, 11);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // smallest linear level that encodes to code j or above
   function automatic int thr_entry(input int j, input int lb);
      logic [255:0] m;
      logic [255:0] lhs;
      logic [255:0] rhs;
      int lo;
      int hi;
      int mid;
      m   = (256'd1 << lb) - 256'd1;
      rhs = big_pow(m, 5) * big_pow(256'(2 * j - 1), 11);
      lo  = 0;
      hi  = 1 << lb;
      if (j == 0) return 0;
      while (lo < hi) begin
         mid = lo + ((hi - lo) >> 1);
         lhs = big_pow(256'(mid), 5) * big_pow(256'd510, 11);
         if (lhs >= rhs) hi = mid;
         else lo = mid + 1;
      end
      return lo;
   endfunction

endpackage

@@ rtl/core/sbd_ram.sv @@
// generic simple dual-port ram with registered read
// no dependencies
module sbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sbd_encode.sv @@
// linear level to srgb byte by binary search over the midpoint thresholds
// depends on sbd_pkg for the threshold builder
module sbd_encode #(
   parameter int LINEAR_BITS = 16
) (
   input  logic [LINEAR_BITS-1:0] level,
   output logic [7:0]             code
);
   import sbd_pkg::*;

   logic [LINEAR_BITS-1:0] thr [256];

   // threshold table, built at elaboration
   for (genvar g = 0; g < 256; g++) begin : g_thr
      localparam int TV = thr_entry(g, LINEAR_BITS);
      assign thr[g] = TV[LINEAR_BITS-1:0];
   end

   // eight halving steps, msb first
   always_comb begin
      logic [7:0] code_v;
      logic [7:0] cand;
      code_v = 8'd0;
      for (int b = 7; b >= 0; b--) begin
         cand = code_v | (8'd1 << b);
         if (thr[cand] <= level) code_v = cand;
      end
      code = code_v;
   end

endmodule

@@ rtl/core/srgb_box_downsample_2x2.sv @@
// srgb box downsampler top level: counters, pair line store, pipeline
// depends on sbd_pkg, sbd_ram and sbd_encode
//
// Takes one RGBA8 pixel per clock in raster order and gives one pixel per
// 2x2 block, averaged in linear light. A pixel is accepted in every cycle
// unless a finished result is held by rsp_stall; the pair line store is one
// write and one read port RAM of MAX_WIDTH/2 words, touched at most once per
// pixel, so it never limits the rate. Stages a, b and c register a result
// after the bottom-right pixel of its block. The even row writes its pair
// sums and the odd row reads them back, at least two pixels later, so no
// forwarding is needed. Writing either size register restarts the level.
module srgb_box_downsample_2x2 #(
   parameter int MAX_WIDTH   = 4096,
   parameter int LINEAR_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sbd_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sbd_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 csr_write,
   input  logic [sbd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sbd_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import sbd_pkg::*;

   localparam int PAIRS = MAX_WIDTH / 2;
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int WW    = XW + 1;
   localparam int SW    = LINEAR_BITS + 1;
   localparam int MW    = 3 * SW + 9;

   // linear table, built at elaboration
   logic [LINEAR_BITS-1:0] lin_tab [256];
   for (genvar g = 0; g < 256; g++) begin : g_lin
      localparam int LV = lin_entry(g, LINEAR_BITS);
      assign lin_tab[g] = LV[LINEAR_BITS-1:0];
   end

   logic [CSR_DATA_BITS-1:0] width_ff, height_ff;
   logic [XW-1:0]            col_ff, col_in;
   logic [CSR_DATA_BITS-1:0] row_ff, row_in;
   logic [LINEAR_BITS-1:0]   left_r_ff, left_g_ff, left_b_ff;
   logic [7:0]               left_a_ff;

   logic [WW-1:0]            w_eff;
   logic [CSR_DATA_BITS-1:0] h_eff;
   logic                     move, accept, odd_col, odd_row, is_last;
   logic [SW-1:0]            s_r, s_g, s_b;
   logic [8:0]               s_a;
   logic [MW-1:0]            rd_data;

   // effective sizes
   always_comb begin
      if (width_ff < 13'd2) w_eff = WW'(2);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(width_ff);
      h_eff = (height_ff < 13'd2) ? 13'd2 : height_ff;
   end

   // handshake: the pipeline moves whenever the output slot can take data
   assign move      = !rsp_valid || !rsp_stall;
   assign req_stall = !move;
   assign accept    = req_valid && move;
   assign odd_col   = col_ff[0];
   assign odd_row   = row_ff[0];
   assign is_last   = (WW'(col_ff) == ((w_eff & ~WW'(1)) - WW'(1)))
                   && (row_ff == ((h_eff & ~13'd1) - 13'd1));

   // horizontal pair sums
   assign s_r = SW'(left_r_ff) + SW'(lin_tab[req_payload.red]);
   assign s_g = SW'(left_g_ff) + SW'(lin_tab[req_payload.green]);
   assign s_b = SW'(left_b_ff) + SW'(lin_tab[req_payload.blue]);
   assign s_a = 9'(left_a_ff) + 9'(req_payload.alpha);

   // next position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if ((WW'(col_ff) + WW'(1)) >= w_eff) begin
         col_in = '0;
         row_in = ((14'(row_ff) + 14'd1) >= 14'(h_eff)) ? '0 : row_ff + 13'd1;
      end else begin
         col_in = col_ff + XW'(1);
      end
   end

   // registers and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd256;
         height_ff <= 13'd256;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_write && (csr_index == CSR_SOURCE_WIDTH
                              || csr_index == CSR_SOURCE_HEIGHT)) begin
         if (csr_index == CSR_SOURCE_WIDTH) width_ff <= csr_data;
         else height_ff <= csr_data;
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // left pixel of the current pair
   always_ff @(posedge clock) begin
      if (reset) begin
         left_r_ff <= '0;
         left_g_ff <= '0;
         left_b_ff <= '0;
         left_a_ff <= '0;
      end else if (accept && !odd_col) begin
         left_r_ff <= lin_tab[req_payload.red];
         left_g_ff <= lin_tab[req_payload.green];
         left_b_ff <= lin_tab[req_payload.blue];
         left_a_ff <= req_payload.alpha;
      end
   end

   // pair line store: even rows write, odd rows read
   sbd_ram #(.WIDTH(MW), .DEPTH(PAIRS)) u_pair_ram (
      .clock   (clock),
      .wr_en   (accept && odd_col && !odd_row),
      .wr_addr (col_ff[XW-1:1]),
      .wr_data ({s_r, s_g, s_b, s_a}),
      .rd_en   (accept && odd_col && odd_row),
      .rd_addr (col_ff[XW-1:1]),
      .rd_data (rd_data)
   );

   logic                   a_valid_ff, b_valid_ff, c_valid_ff;
   logic                   a_last_ff, b_last_ff;
   logic [SW-1:0]          a_r_ff, a_g_ff, a_b_ff;
   logic [8:0]             a_a_ff;
   logic [LINEAR_BITS-1:0] b_r_ff, b_g_ff, b_b_ff;
   logic [7:0]             b_a_ff;
   logic [SW:0]            t_r, t_g, t_b;
   logic [9:0]             t_a;
   logic [7:0]             e_r, e_g, e_b;
   rsp_payload_type        rsp_ff;

   // vertical sums
   assign t_r = (SW+1)'(rd_data[MW-1 -: SW])      + (SW+1)'(a_r_ff);
   assign t_g = (SW+1)'(rd_data[MW-1-SW -: SW])   + (SW+1)'(a_g_ff);
   assign t_b = (SW+1)'(rd_data[MW-1-2*SW -: SW]) + (SW+1)'(a_b_ff);
   assign t_a = 10'(rd_data[8:0]) + 10'(a_a_ff);

   sbd_encode #(.LINEAR_BITS(LINEAR_BITS)) u_enc_r (.level(b_r_ff), .code(e_r));
   sbd_encode #(.LINEAR_BITS(LINEAR_BITS)) u_enc_g (.level(b_g_ff), .code(e_g));
   sbd_encode #(.LINEAR_BITS(LINEAR_BITS)) u_enc_b (.level(b_b_ff), .code(e_b));

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (move) begin
         a_valid_ff <= accept && odd_col && odd_row;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // pipeline payload: pair sum, average, encode
   always_ff @(posedge clock) begin
      if (move) begin
         a_r_ff    <= s_r;
         a_g_ff    <= s_g;
         a_b_ff    <= s_b;
         a_a_ff    <= s_a;
         a_last_ff <= is_last;
         b_r_ff    <= t_r[SW:2];
         b_g_ff    <= t_g[SW:2];
         b_b_ff    <= t_b[SW:2];
         b_a_ff    <= t_a[9:2];
         b_last_ff <= a_last_ff;
         rsp_ff.out_red       <= e_r;
         rsp_ff.out_green     <= e_g;
         rsp_ff.out_blue      <= e_b;
         rsp_ff.out_alpha     <= b_a_ff;
         rsp_ff.last_of_level <= b_last_ff;
      end
   end

   assign rsp_valid   = c_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/core/sbd_checker.sv @@
// port-level checks for the srgb 2x2 downsampler, bound to the top level
// depends on sbd_pkg and assert_macros.svh
`include "assert_macros.svh"
module sbd_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input sbd_pkg::rsp_payload_type rsp_payload
);
   import sbd_pkg::*;

   // a held result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // a held result keeps its payload
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))
   // the input side only waits behind a held result
   `ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // nothing comes out right after reset
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
   // a stalled input transaction stays offered
   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid)

endmodule

bind srgb_box_downsample_2x2 sbd_checker u_sbd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
